// ===== rtl/rai_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rai_pkg
// Shared types and constants for the register ALU instruction group.
// ============================================================================
package rai_pkg;

    localparam int unsigned REG_W   = 8;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned PC_W    = 16;
    localparam int unsigned INSTR_W = 16;
    localparam int unsigned OUT_W   = 32;

    localparam logic [ADDR_W-1:0] FLAG_REG = 4'hF;
    localparam logic [PC_W-1:0]   PC_RESET = 16'h0200;
    localparam logic [PC_W-1:0]   PC_STEP  = 16'h0002;

    // Operation nibble codes.
    localparam logic [3:0] OP_MOV = 4'h0;
    localparam logic [3:0] OP_OR  = 4'h1;
    localparam logic [3:0] OP_AND = 4'h2;
    localparam logic [3:0] OP_XOR = 4'h3;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_SUB = 4'h5;
    localparam logic [3:0] OP_SHR = 4'h6;
    localparam logic [3:0] OP_SBN = 4'h7;
    localparam logic [3:0] OP_SHL = 4'hE;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_BAD = 1'b1;

    typedef struct packed {
        logic              status;
        logic [REG_W-1:0]  res;
        logic              flag;
        logic              wflag;
    } t_alu_res;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [REG_W-1:0]  data;
    } t_wr_req;

endpackage

// ===== rtl/rai_regfile.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rai_regfile
// General register memory: two registered read ports, one write port.
// Per-entry valid bits make never-written registers read as zero.
// ============================================================================
module rai_regfile
    import rai_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr_x,
    input  logic [ADDR_W-1:0] i_rd_addr_y,
    input  t_wr_req           i_wr,
    output logic [REG_W-1:0]  o_rd_x,
    output logic [REG_W-1:0]  o_rd_y
);

    logic [REG_W-1:0]        r_mem [2**ADDR_W];
    logic [2**ADDR_W-1:0]    r_vld;
    logic [REG_W-1:0]        r_rd_x;
    logic [REG_W-1:0]        r_rd_y;
    logic                    r_vx;
    logic                    r_vy;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_x <= r_mem[i_rd_addr_x];
            r_rd_y <= r_mem[i_rd_addr_y];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_vx  <= 1'b0;
            r_vy  <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vx <= r_vld[i_rd_addr_x];
                r_vy <= r_vld[i_rd_addr_y];
            end
        end
    end

    assign o_rd_x = r_vx ? r_rd_x : '0;
    assign o_rd_y = r_vy ? r_rd_y : '0;

endmodule

// ===== rtl/rai_alu.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rai_alu
// Eight-bit ALU for the 8XYN operations, with flag generation.
// ============================================================================
module rai_alu
    import rai_pkg::*;
(
    input  logic [3:0]       i_op,
    input  logic [REG_W-1:0] i_vx,
    input  logic [REG_W-1:0] i_vy,
    output t_alu_res         o_res
);

    logic [REG_W:0] w_sum;
    logic [REG_W:0] w_dxy;
    logic [REG_W:0] w_dyx;

    assign w_sum = {1'b0, i_vx} + {1'b0, i_vy};
    assign w_dxy = {1'b0, i_vx} - {1'b0, i_vy};
    assign w_dyx = {1'b0, i_vy} - {1'b0, i_vx};

    always_comb begin
        o_res = '{status: STAT_OK, res: '0, flag: 1'b0, wflag: 1'b0};
        unique case (i_op)
            OP_MOV: o_res.res = i_vy;
            OP_OR:  o_res.res = i_vx | i_vy;
            OP_AND: o_res.res = i_vx & i_vy;
            OP_XOR: o_res.res = i_vx ^ i_vy;
            OP_ADD: begin
                o_res.res   = w_sum[REG_W-1:0];
                o_res.flag  = w_sum[REG_W];
                o_res.wflag = 1'b1;
            end
            // Borrow shows in the top bit; the flag is its inverse.
            OP_SUB: begin
                o_res.res   = w_dxy[REG_W-1:0];
                o_res.flag  = ~w_dxy[REG_W];
                o_res.wflag = 1'b1;
            end
            OP_SHR: begin
                o_res.res   = {1'b0, i_vx[REG_W-1:1]};
                o_res.flag  = i_vx[0];
                o_res.wflag = 1'b1;
            end
            OP_SBN: begin
                o_res.res   = w_dyx[REG_W-1:0];
                o_res.flag  = ~w_dyx[REG_W];
                o_res.wflag = 1'b1;
            end
            OP_SHL: begin
                o_res.res   = {i_vx[REG_W-2:0], 1'b0};
                o_res.flag  = i_vx[REG_W-1];
                o_res.wflag = 1'b1;
            end
            default: o_res.status = STAT_BAD;
        endcase
    end

endmodule

// ===== rtl/register_alu_instruction_group.sv =====
`timescale 1ns / 1ps
// ============================================================================
// register_alu_instruction_group
// Executes 8XYN register ALU instructions against a 16 x 8 register memory.
// ============================================================================
// Pipeline: register read, then execute, write back and output register.
// Throughput: one instruction per cycle while the result side accepts; a
// read-after-write hazard between adjacent instructions is resolved by
// forwarding, so there are no bubbles.
// Reset: synchronous, active low; registers read as zero, PC is 0x0200, and
// the pipeline and output register are emptied.
module register_alu_instruction_group
    import rai_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [INSTR_W-1:0] s_axis_tdata,  // [15:0] instruction
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] status, [16:1] next_pc, [24:17] dest_value, [25] flag_value,
    // [26] flag_written, [31:27] zero
    output logic [OUT_W-1:0]   m_axis_tdata
);

    logic               r_s1_vld;
    logic [INSTR_W-1:0] r_s1_instr;
    logic               r_ov;
    logic [OUT_W-1:0]   r_out;
    logic [PC_W-1:0]    r_pc;
    logic [REG_W-1:0]   r_vf;
    t_wr_req            r_fwd;

    logic               n_s1_vld;
    logic [PC_W-1:0]    n_pc;
    logic [REG_W-1:0]   n_vf;
    t_wr_req            n_fwd;

    logic               w_s1_move;
    logic               w_accept_slot;
    logic               w_commit;
    logic [ADDR_W-1:0]  w_x;
    logic [ADDR_W-1:0]  w_y;
    logic [REG_W-1:0]   w_rd_x;
    logic [REG_W-1:0]   w_rd_y;
    logic [REG_W-1:0]   w_vx;
    logic [REG_W-1:0]   w_vy;
    t_alu_res           w_alu;
    t_wr_req            w_wr;
    logic               w_ok;

    assign w_s1_move     = !r_ov || m_axis_tready;
    assign w_accept_slot = !r_s1_vld || w_s1_move;
    assign s_axis_tready = w_accept_slot;
    assign w_commit      = r_s1_vld && w_s1_move;

    rai_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_accept_slot),
        .i_rd_addr_x (s_axis_tdata[11:8]),
        .i_rd_addr_y (s_axis_tdata[7:4]),
        .i_wr        (w_wr),
        .o_rd_x      (w_rd_x),
        .o_rd_y      (w_rd_y)
    );

    assign w_x = r_s1_instr[11:8];
    assign w_y = r_s1_instr[7:4];

    // V15 lives in its own register. The memory read missed the write of the
    // instruction just ahead, so that write is forwarded.
    always_comb begin
        priority if (w_x == FLAG_REG) begin
            w_vx = r_vf;
        end else if (r_fwd.we && r_fwd.addr == w_x) begin
            w_vx = r_fwd.data;
        end else begin
            w_vx = w_rd_x;
        end
        priority if (w_y == FLAG_REG) begin
            w_vy = r_vf;
        end else if (r_fwd.we && r_fwd.addr == w_y) begin
            w_vy = r_fwd.data;
        end else begin
            w_vy = w_rd_y;
        end
    end

    rai_alu u_alu (
        .i_op  (r_s1_instr[3:0]),
        .i_vx  (w_vx),
        .i_vy  (w_vy),
        .o_res (w_alu)
    );

    assign w_ok = (w_alu.status == STAT_OK);

    always_comb begin
        w_wr.we   = w_commit && w_ok && (w_x != FLAG_REG);
        w_wr.addr = w_x;
        w_wr.data = w_alu.res;

        n_pc = r_pc;
        n_vf = r_vf;
        if (w_commit && w_ok) begin
            n_pc = r_pc + PC_STEP;
            if (w_alu.wflag) begin
                n_vf = {{(REG_W-1){1'b0}}, w_alu.flag};
            end else if (w_x == FLAG_REG) begin
                n_vf = w_alu.res;
            end
        end

        n_fwd = r_fwd;
        if (w_accept_slot) begin
            n_fwd = w_wr;
        end

        n_s1_vld = r_s1_vld;
        if (w_accept_slot) begin
            n_s1_vld = s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_ov     <= 1'b0;
            r_pc     <= PC_RESET;
            r_vf     <= '0;
            r_fwd    <= '0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_pc     <= n_pc;
            r_vf     <= n_vf;
            r_fwd    <= n_fwd;
            if (w_s1_move) begin
                r_ov <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept_slot) begin
            r_s1_instr <= s_axis_tdata;
        end
        if (w_commit) begin
            if (w_ok) begin
                r_out <= {5'b0, w_alu.wflag, w_alu.flag, w_alu.res, n_pc, STAT_OK};
            end else begin
                r_out <= {5'b0, 1'b0, 1'b0, {REG_W{1'b0}}, r_pc, STAT_BAD};
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    // Only a committed, valid instruction moves the program counter.
    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_ok) |=> (r_pc == $past(r_pc) + PC_STEP))
        else $error("program counter did not advance by two");

    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_commit && w_ok) |=> $stable(r_pc))
        else $error("program counter changed without a committed instruction");

    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0] == STAT_BAD) |->
            (m_axis_tdata[26:17] == '0))
        else $error("unknown operation reported nonzero results");

    a_no_wr_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_s1_move) |-> !w_wr.we)
        else $error("register write while the pipeline is stalled");

endmodule

// ===== bench/register_alu_instruction_group_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// register_alu_instruction_group_tb
// Streams 8XYN instructions into the register ALU block and checks every result
// against its typed table value or a local model of the register file and program counter.
// A directed table covers the operations, flags and odd encodings. Random
// traffic with varying back-pressure follows, ending with a full-rate phase.
// ============================================================================
module register_alu_instruction_group_tb;
    import rai_pkg::*;

    typedef struct packed {
        logic             status;
        logic [PC_W-1:0]  next_pc;
        logic [REG_W-1:0] dest;
        logic             flag;
        logic             wflag;
    } t_alu_outcome;

    typedef struct packed {
        logic [INSTR_W-1:0] instr;
        logic               typed;
        t_alu_outcome       want;
    } t_stim_row;

    localparam int NUM_DIRECTED     = 25;
    localparam int RANDOM_PER_PHASE = 410;
    localparam int HOLD_CYCLES      = 64;
    localparam int DRAIN_CYCLES     = 8;
    // Longest legal quiet stretch is the long receiver hold plus random stalls;
    // this is many times that.
    localparam int STALL_LIMIT      = 2000;

    localparam logic [3:0] ALU_OPS [9] = '{OP_MOV, OP_OR, OP_AND, OP_XOR, OP_ADD,
                                           OP_SUB, OP_SHR, OP_SBN, OP_SHL};

    // Typed rows follow directly from the reset state; the others are predicted.
    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        {16'h8123, 1'b1, STAT_OK,  16'h0202, 8'h00, 1'b0, 1'b0},
        {16'h800D, 1'b1, STAT_BAD, 16'h0202, 8'h00, 1'b0, 1'b0},
        {16'h8005, 1'b1, STAT_OK,  16'h0204, 8'h00, 1'b1, 1'b1},
        {16'h81F0, 1'b0, 27'h0},   // V1 picks up the flag
        {16'h8215, 1'b0, 27'h0},   // 0 - 1 borrows
        {16'h8320, 1'b0, 27'h0},
        {16'h833E, 1'b0, 27'h0},   // shift out of bit 7
        {16'h8226, 1'b0, 27'h0},
        {16'h8124, 1'b0, 27'h0},
        {16'h8314, 1'b0, 27'h0},   // carry out
        {16'h8F24, 1'b0, 27'h0},   // X is the flag register
        {16'h8F35, 1'b0, 27'h0},
        {16'h8431, 1'b0, 27'h0},
        {16'h8412, 1'b0, 27'h0},
        {16'h8537, 1'b0, 27'h0},
        {16'h8555, 1'b0, 27'h0},   // equal operands, no borrow
        {16'h8FF6, 1'b0, 27'h0},
        {16'h8FFE, 1'b0, 27'h0},
        {16'hF123, 1'b0, 27'h0},   // top nibble is ignored
        {16'h0340, 1'b0, 27'h0},
        {16'h5009, 1'b0, 27'h0},
        {16'h800A, 1'b0, 27'h0},
        {16'hA10B, 1'b0, 27'h0},
        {16'h800C, 1'b0, 27'h0},
        {16'hFFFF, 1'b0, 27'h0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [INSTR_W-1:0] s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;

    logic [REG_W-1:0]   gpr_model [16];
    logic [PC_W-1:0]    pc_model;
    t_alu_outcome       pending_outcomes [$];
    int                 error_count;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    bit                 hold_request;

    register_alu_instruction_group u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Executes one instruction on the local register file and returns the
    // result the block should report for it.
    function automatic t_alu_outcome execute_alu_instr(input logic [INSTR_W-1:0] instr);
        logic [3:0]       x;
        logic [3:0]       y;
        logic [3:0]       op;
        logic [REG_W-1:0] vx;
        logic [REG_W-1:0] vy;
        logic [REG_W:0]   wide;
        t_alu_outcome     o;
        x  = instr[11:8];
        y  = instr[7:4];
        op = instr[3:0];
        vx = gpr_model[x];
        vy = gpr_model[y];
        o  = '0;
        o.status = STAT_OK;
        case (op)
            OP_MOV: o.dest = vy;
            OP_OR:  o.dest = vx | vy;
            OP_AND: o.dest = vx & vy;
            OP_XOR: o.dest = vx ^ vy;
            OP_ADD: begin
                wide    = {1'b0, vx} + {1'b0, vy};
                o.dest  = wide[REG_W-1:0];
                o.flag  = wide[REG_W];
                o.wflag = 1'b1;
            end
            OP_SUB: begin
                o.dest  = vx - vy;
                o.flag  = (vx >= vy);
                o.wflag = 1'b1;
            end
            OP_SHR: begin
                o.dest  = vx >> 1;
                o.flag  = vx[0];
                o.wflag = 1'b1;
            end
            OP_SBN: begin
                o.dest  = vy - vx;
                o.flag  = (vy >= vx);
                o.wflag = 1'b1;
            end
            OP_SHL: begin
                o.dest  = {vx[REG_W-2:0], 1'b0};
                o.flag  = vx[REG_W-1];
                o.wflag = 1'b1;
            end
            default: o.status = STAT_BAD;
        endcase
        if (o.status == STAT_BAD) begin
            o = '0;
            o.status  = STAT_BAD;
            o.next_pc = pc_model;
        end else begin
            gpr_model[x] = o.dest;
            // The flag write comes second, so it overrides a destination of V15.
            if (o.wflag) begin
                gpr_model[FLAG_REG] = {{(REG_W-1){1'b0}}, o.flag};
            end
            pc_model  = pc_model + PC_STEP;
            o.next_pc = pc_model;
        end
        return o;
    endfunction

    // Mostly well-formed 8XYN words; the rest carry any operation nibble and
    // any top nibble.
    function automatic logic [INSTR_W-1:0] random_instr();
        logic [3:0] top;
        logic [3:0] op;
        top = ($urandom_range(99) < 80) ? 4'h8 : 4'($urandom_range(15));
        op  = ($urandom_range(99) < 85) ? ALU_OPS[$urandom_range(8)]
                                        : 4'($urandom_range(15));
        return {top, 4'($urandom_range(15)), 4'($urandom_range(15)), op};
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_instr(input logic [INSTR_W-1:0] instr, input logic typed,
                              input t_alu_outcome want);
        t_alu_outcome predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= instr;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = execute_alu_instr(instr);
        pending_outcomes.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_alu_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with no instruction outstanding: 0x%0h",
                       m_axis_tdata);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("status",       want.status,  m_axis_tdata[0]);
                check_field("next_pc",      want.next_pc, m_axis_tdata[16:1]);
                check_field("dest_value",   want.dest,    m_axis_tdata[24:17]);
                check_field("flag_value",   want.flag,    m_axis_tdata[25]);
                check_field("flag_written", want.wflag,   m_axis_tdata[26]);
                check_field("padding",      0,            m_axis_tdata[OUT_W-1:27]);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off when requested so the
    // pipeline fills and the input stalls.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        error_count   = 0;
        hold_request  = 1'b0;
        tx_idle_pct   = 28;
        rx_idle_pct   = 68;
        pc_model      = PC_RESET;
        for (int i = 0; i < 16; i++) begin
            gpr_model[i] = '0;
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_instr(DIRECTED_ROWS[i].instr, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        hold_request = 1'b1;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            send_instr(random_instr(), 1'b0, '0);
        end

        tx_idle_pct = 68;
        rx_idle_pct = 28;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            send_instr(random_instr(), 1'b0, '0);
        end

        // Full rate on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            send_instr(random_instr(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
